// ===== src/lusp_pkg.sv =====
// Shared types, constants and helpers for the scaled-pivot LU block.
// Used by the controller, the datapath, the divider, the top level and the checker.
// No dependencies.
`default_nettype none

package lusp_pkg;

	// Matrix geometry and number format
	localparam int N_MAX     = 8;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W    = 32;
	localparam int IDX_W     = $clog2(N_MAX);
	localparam int CNT_W     = IDX_W + 1;
	localparam int ADDR_W    = 2 * IDX_W;
	localparam int MEM_DEPTH = 1 << ADDR_W;
	localparam int SIZE_W    = 4;
	localparam int DIVD_W    = DATA_W + FRAC_BITS;
	localparam int PROD_W    = 2 * DATA_W;
	localparam int MS_W      = PROD_W - FRAC_BITS + 2;

	// Stream widths
	localparam int S_TUSER_W = 4;
	localparam int S_TDATA_W = ((2 * IDX_W + DATA_W + 7) / 8) * 8;
	localparam int M_TUSER_W = 1;
	localparam int M_TDATA_W = ((DATA_W + 1 + 7) / 8) * 8;

	localparam logic [DATA_W-1:0] Q_ONE = DATA_W'(1) << FRAC_BITS;

	// Opcodes, read selectors, result kinds
	localparam logic [1:0] OP_WRITE  = 2'd0;
	localparam logic [1:0] OP_DECOMP = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] SEL_L = 2'd0;
	localparam logic [1:0] SEL_U = 2'd1;
	localparam logic [1:0] SEL_P = 2'd2;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_READ   = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE, ST_RD_RESP, ST_INIT, ST_K_START, ST_ROW_START, ST_ROW_RD, ST_ROW_CMP,
		ST_RATIO, ST_RATIO_WAIT, ST_NEXT_ROW, ST_SWAP_CHK, ST_SW_RD_K, ST_SW_RD_T,
		ST_SW_WR_K, ST_SW_WR_T, ST_PIV_RD, ST_PIV_CHK, ST_EL_RD, ST_EL_DIV, ST_EL_WAIT,
		ST_EL_WR, ST_MS_RD_K, ST_MS_RD_I, ST_MS_WR, ST_EL_NEXT, ST_K_NEXT, ST_DIAG,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {UW_IN, UW_TMP, UW_RD, UW_ZERO, UW_MSUB} u_wsel_t;
	typedef enum logic [1:0] {LW_TMP, LW_RD, LW_M, LW_ONE} l_wsel_t;
	typedef enum logic {DS_RATIO, DS_ELIM} div_src_t;

	// Controller to datapath
	typedef struct packed {
		logic              u_re;
		logic              u_we;
		logic [ADDR_W-1:0] u_addr;
		u_wsel_t           u_wsel;
		logic              l_re;
		logic              l_we;
		logic [ADDR_W-1:0] l_addr;
		l_wsel_t           l_wsel;
		logic              l_clr;
		logic              perm_init;
		logic              perm_swap;
		logic              err_clr;
		logic              err_set;
		logic              cap_req;
		logic              mx_clr;
		logic              mx_upd;
		logic              cap_a;
		logic              best_clr;
		logic              best_upd;
		logic              div_start;
		div_src_t          div_src;
		logic              cap_tmp;
		logic              cap_piv;
		logic              cap_m;
		logic              cap_prod;
		logic              out_stat;
		logic              out_read;
		logic [IDX_W-1:0]  k_idx;
		logic [IDX_W-1:0]  i_idx;
	} lusp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic             div_done;
		logic             mx_zero;
		logic             piv_zero;
		logic [IDX_W-1:0] t_idx;
		logic             out_blocked;
	} lusp_stat_t;

	function automatic logic [ADDR_W-1:0] elem_addr(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		return {r, c};
	endfunction

	function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
		return v[DATA_W-1] ? (~v + DATA_W'(1)) : v;
	endfunction

endpackage

`default_nettype wire

// ===== src/lusp_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lusp_pkg.
`default_nettype none

module lusp_div (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [lusp_pkg::DIVD_W-1:0] dividend,
	input  wire logic [lusp_pkg::DATA_W-1:0] divisor,
	output logic                            done,
	output logic [lusp_pkg::DIVD_W-1:0]     quotient
);
	import lusp_pkg::*;

	localparam int DCNT_W = $clog2(DIVD_W + 1);

	logic              busy_q, done_q;
	logic [DCNT_W-1:0] cnt_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DATA_W-1:0] rem_q, den_q;
	logic [DATA_W:0]   rem_sh, diff;
	logic              ge;

	// One trial subtract per cycle
	always_comb begin
		rem_sh = {rem_q, quo_q[DIVD_W-1]};
		diff   = rem_sh - {1'b0, den_q};
		ge     = rem_sh >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DCNT_W'(DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DCNT_W'(1);
				if (cnt_q == DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], ge};
			rem_q <= ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== src/lusp_dp.sv =====
// Datapath: U and L stores, permutation, ratio search, multiply-subtract, result register.
// Depends on lusp_pkg and lusp_div.
`default_nettype none

module lusp_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire lusp_pkg::lusp_cmd_t         cmd,
	output lusp_pkg::lusp_stat_t             stat,
	input  wire logic [lusp_pkg::DATA_W-1:0] in_value,
	input  wire logic [lusp_pkg::IDX_W-1:0]  in_row,
	input  wire logic [lusp_pkg::IDX_W-1:0]  in_col,
	input  wire logic [1:0]                  in_sel,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic                             out_kind,
	output logic [lusp_pkg::DATA_W-1:0]      out_value,
	output logic                             out_status
);
	import lusp_pkg::*;

	// Stores
	logic [DATA_W-1:0] u_mem [MEM_DEPTH];
	logic [DATA_W-1:0] l_mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] l_vld_q;
	logic [DATA_W-1:0] u_rd_q, l_rd_q;
	logic              l_rv_q;
	logic [IDX_W-1:0]  perm_q [N_MAX];

	// Working registers
	logic                     err_q;
	logic [DATA_W-1:0]        mx_q, a_q, best_q;
	logic [IDX_W-1:0]         t_q;
	logic [DATA_W-1:0]        tmp_u_q, tmp_l_q, piv_q;
	logic                     sgn_q;
	logic signed [DATA_W-1:0] m_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic [1:0]               rsel_q;
	logic [IDX_W-1:0]         rrow_q, rcol_q;

	// Result register
	logic              out_vld_q, out_kind_q, out_stat_q;
	logic [DATA_W-1:0] out_val_q;

	logic [DATA_W-1:0] l_val, u_wdata, l_wdata, rd_mag, rd_val, msub, m_sat;
	logic [DATA_W-1:0] num, den;
	logic [DIVD_W-1:0] quo;
	logic              div_done;
	logic [PROD_W-1:0] pmag;
	logic [MS_W-1:0]   rs, xd, dd;

	assign l_val  = l_rv_q ? l_rd_q : '0;
	assign rd_mag = mag(u_rd_q);

	// Shared divider: scale ratio or elimination multiplier
	always_comb begin
		num = (cmd.div_src == DS_RATIO) ? a_q : rd_mag;
		den = (cmd.div_src == DS_RATIO) ? mx_q : mag(piv_q);
	end

	lusp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({num, {FRAC_BITS{1'b0}}}),
		.divisor  (den),
		.done     (div_done),
		.quotient (quo)
	);

	// Multiplier saturation to 32 bits
	always_comb begin
		if (quo[DIVD_W-1:DATA_W-1] != '0)
			m_sat = sgn_q ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		else
			m_sat = sgn_q ? (~quo[DATA_W-1:0] + DATA_W'(1)) : quo[DATA_W-1:0];
	end

	// x - trunc(m*u >> FRAC_BITS), saturated
	always_comb begin
		pmag = prod_s1[PROD_W-1] ? (~prod_s1 + PROD_W'(1)) : prod_s1;
		rs   = {2'b00, pmag[PROD_W-1:FRAC_BITS]};
		if (prod_s1[PROD_W-1])
			rs = ~rs + MS_W'(1);
		xd = {{(MS_W-DATA_W){u_rd_q[DATA_W-1]}}, u_rd_q};
		dd = xd - rs;
		if ((dd[MS_W-1:DATA_W-1] != '0) && (dd[MS_W-1:DATA_W-1] != '1))
			msub = dd[MS_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
		else
			msub = dd[DATA_W-1:0];
	end

	// Write data select
	always_comb begin
		case (cmd.u_wsel)
			UW_IN:   u_wdata = in_value;
			UW_TMP:  u_wdata = tmp_u_q;
			UW_RD:   u_wdata = u_rd_q;
			UW_MSUB: u_wdata = msub;
			default: u_wdata = '0;
		endcase
		case (cmd.l_wsel)
			LW_TMP:  l_wdata = tmp_l_q;
			LW_RD:   l_wdata = l_val;
			LW_M:    l_wdata = m_q;
			default: l_wdata = Q_ONE;
		endcase
	end

	// U store, registered read
	always_ff @(posedge clk) begin
		if (cmd.u_we)
			u_mem[cmd.u_addr] <= u_wdata;
		if (cmd.u_re)
			u_rd_q <= u_mem[cmd.u_addr];
	end

	// L store, registered read; entries not written since clear read as zero
	always_ff @(posedge clk) begin
		if (cmd.l_we)
			l_mem[cmd.l_addr] <= l_wdata;
		if (cmd.l_re)
			l_rd_q <= l_mem[cmd.l_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_vld_q <= '0;
			l_rv_q  <= 1'b0;
		end else begin
			if (cmd.l_clr)
				l_vld_q <= '0;
			else if (cmd.l_we)
				l_vld_q[cmd.l_addr] <= 1'b1;
			if (cmd.l_re)
				l_rv_q <= l_vld_q[cmd.l_addr];
		end
	end

	// Permutation and error flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < N_MAX; p++)
				perm_q[p] <= IDX_W'(p);
			err_q <= 1'b0;
		end else begin
			if (cmd.perm_init) begin
				for (int p = 0; p < N_MAX; p++)
					perm_q[p] <= IDX_W'(p);
			end else if (cmd.perm_swap) begin
				perm_q[cmd.k_idx] <= perm_q[t_q];
				perm_q[t_q]       <= perm_q[cmd.k_idx];
			end
			if (cmd.err_clr)
				err_q <= 1'b0;
			else if (cmd.err_set)
				err_q <= 1'b1;
		end
	end

	// Pivot search, swap and elimination registers
	always_ff @(posedge clk) begin
		if (cmd.mx_clr)
			mx_q <= '0;
		else if (cmd.mx_upd && (rd_mag > mx_q))
			mx_q <= rd_mag;
		if (cmd.mx_upd && cmd.cap_a)
			a_q <= rd_mag;
		if (cmd.best_clr) begin
			best_q <= '0;
			t_q    <= cmd.k_idx;
		end else if (cmd.best_upd && (quo[DATA_W-1:0] > best_q)) begin
			best_q <= quo[DATA_W-1:0];
			t_q    <= cmd.i_idx;
		end
		if (cmd.cap_tmp) begin
			tmp_u_q <= u_rd_q;
			tmp_l_q <= l_val;
		end
		if (cmd.cap_piv)
			piv_q <= u_rd_q;
		if (cmd.div_start)
			sgn_q <= u_rd_q[DATA_W-1] ^ piv_q[DATA_W-1];
		if (cmd.cap_m)
			m_q <= m_sat;
		if (cmd.cap_prod)
			prod_s1 <= m_q * $signed(u_rd_q);
		if (cmd.cap_req) begin
			rsel_q <= in_sel;
			rrow_q <= in_row;
			rcol_q <= in_col;
		end
	end

	// Read result select
	always_comb begin
		unique case (rsel_q)
			SEL_L:   rd_val = l_val;
			SEL_U:   rd_val = u_rd_q;
			SEL_P:   rd_val = (perm_q[rrow_q] == rcol_q) ? Q_ONE : '0;
			default: rd_val = '0;
		endcase
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (cmd.out_stat || cmd.out_read)
			out_vld_q <= 1'b1;
		else if (out_ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_stat) begin
			out_kind_q <= KIND_STATUS;
			out_val_q  <= '0;
			out_stat_q <= err_q;
		end else if (cmd.out_read) begin
			out_kind_q <= KIND_READ;
			out_val_q  <= rd_val;
			out_stat_q <= 1'b0;
		end
	end

	assign out_valid  = out_vld_q;
	assign out_kind   = out_kind_q;
	assign out_value  = out_val_q;
	assign out_status = out_stat_q;

	always_comb begin
		stat.div_done    = div_done;
		stat.mx_zero     = (mx_q == '0);
		stat.piv_zero    = (u_rd_q == '0);
		stat.t_idx       = t_q;
		stat.out_blocked = out_vld_q && !out_ready;
	end

endmodule

`default_nettype wire

// ===== src/lusp_ctrl.sv =====
// Controller: size register, loop counters and the sequencing state machine.
// Depends on lusp_pkg.
`default_nettype none

module lusp_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [1:0]                  in_opcode,
	input  wire logic [lusp_pkg::IDX_W-1:0]  in_row,
	input  wire logic [lusp_pkg::IDX_W-1:0]  in_col,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [lusp_pkg::SIZE_W-1:0] cfg_data,
	output lusp_pkg::lusp_cmd_t              cmd,
	input  wire lusp_pkg::lusp_stat_t        stat
);
	import lusp_pkg::*;

	localparam logic [CNT_W-1:0] LAST_COL = CNT_W'(N_MAX - 1);

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  k_q, k_d, i_q, i_d, j_q, j_d;
	logic [SIZE_W-1:0] size_q;
	logic [CNT_W-1:0]  n, nm1;
	logic [IDX_W-1:0]  k, i, j, t;
	logic              accept;

	// Clamp the dimension to 2..N_MAX
	always_comb begin
		if (size_q < SIZE_W'(2))
			n = CNT_W'(2);
		else if (size_q > SIZE_W'(N_MAX))
			n = CNT_W'(N_MAX);
		else
			n = CNT_W'(size_q);
		nm1 = n - CNT_W'(1);
	end

	assign k         = k_q[IDX_W-1:0];
	assign i         = i_q[IDX_W-1:0];
	assign j         = j_q[IDX_W-1:0];
	assign t         = stat.t_idx;
	assign in_ready  = (state_q == ST_IDLE) && !stat.out_blocked;
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			i_q     <= '0;
			j_q     <= '0;
			size_q  <= SIZE_W'(N_MAX);
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			i_q     <= i_d;
			j_q     <= j_d;
			if (cfg_valid && cfg_ready)
				size_q <= cfg_data;
		end
	end

	// Next state and counters
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		i_d     = i_q;
		j_d     = j_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (in_opcode)
						OP_DECOMP: state_d = ST_INIT;
						OP_READ:   state_d = ST_RD_RESP;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_RD_RESP: state_d = ST_IDLE;
			ST_INIT: begin
				k_d     = '0;
				state_d = ST_K_START;
			end
			ST_K_START: begin
				if (k_q + CNT_W'(1) >= n) begin
					i_d     = '0;
					state_d = ST_DIAG;
				end else begin
					i_d     = k_q;
					state_d = ST_ROW_START;
				end
			end
			ST_ROW_START: begin
				j_d     = '0;
				state_d = ST_ROW_RD;
			end
			ST_ROW_RD: state_d = ST_ROW_CMP;
			ST_ROW_CMP: begin
				if (j_q == nm1)
					state_d = ST_RATIO;
				else begin
					j_d     = j_q + CNT_W'(1);
					state_d = ST_ROW_RD;
				end
			end
			ST_RATIO: state_d = stat.mx_zero ? ST_NEXT_ROW : ST_RATIO_WAIT;
			ST_RATIO_WAIT: begin
				if (stat.div_done)
					state_d = ST_NEXT_ROW;
			end
			ST_NEXT_ROW: begin
				if (i_q == nm1)
					state_d = ST_SWAP_CHK;
				else begin
					i_d     = i_q + CNT_W'(1);
					state_d = ST_ROW_START;
				end
			end
			ST_SWAP_CHK: begin
				if (t == k)
					state_d = ST_PIV_RD;
				else begin
					j_d     = '0;
					state_d = ST_SW_RD_K;
				end
			end
			ST_SW_RD_K: state_d = ST_SW_RD_T;
			ST_SW_RD_T: state_d = ST_SW_WR_K;
			ST_SW_WR_K: state_d = ST_SW_WR_T;
			ST_SW_WR_T: begin
				if (j_q == LAST_COL)
					state_d = ST_PIV_RD;
				else begin
					j_d     = j_q + CNT_W'(1);
					state_d = ST_SW_RD_K;
				end
			end
			ST_PIV_RD: state_d = ST_PIV_CHK;
			ST_PIV_CHK: begin
				if (stat.piv_zero) begin
					i_d     = '0;
					state_d = ST_DIAG;
				end else begin
					i_d     = k_q + CNT_W'(1);
					state_d = ST_EL_RD;
				end
			end
			ST_EL_RD:  state_d = ST_EL_DIV;
			ST_EL_DIV: state_d = ST_EL_WAIT;
			ST_EL_WAIT: begin
				if (stat.div_done)
					state_d = ST_EL_WR;
			end
			ST_EL_WR: begin
				j_d     = k_q + CNT_W'(1);
				state_d = ST_MS_RD_K;
			end
			ST_MS_RD_K: state_d = ST_MS_RD_I;
			ST_MS_RD_I: state_d = ST_MS_WR;
			ST_MS_WR: begin
				if (j_q == nm1)
					state_d = ST_EL_NEXT;
				else begin
					j_d     = j_q + CNT_W'(1);
					state_d = ST_MS_RD_K;
				end
			end
			ST_EL_NEXT: begin
				if (i_q == nm1)
					state_d = ST_K_NEXT;
				else begin
					i_d     = i_q + CNT_W'(1);
					state_d = ST_EL_RD;
				end
			end
			ST_K_NEXT: begin
				k_d     = k_q + CNT_W'(1);
				state_d = ST_K_START;
			end
			ST_DIAG: begin
				if (i_q == nm1)
					state_d = ST_DONE;
				else
					i_d = i_q + CNT_W'(1);
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd       = '0;
		cmd.k_idx = k;
		cmd.i_idx = i;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (in_opcode == OP_WRITE)) begin
					cmd.u_we   = 1'b1;
					cmd.u_addr = elem_addr(in_row, in_col);
					cmd.u_wsel = UW_IN;
				end else if (accept && (in_opcode == OP_READ)) begin
					cmd.u_re    = 1'b1;
					cmd.l_re    = 1'b1;
					cmd.u_addr  = elem_addr(in_row, in_col);
					cmd.l_addr  = elem_addr(in_row, in_col);
					cmd.cap_req = 1'b1;
				end
			end
			ST_RD_RESP: cmd.out_read = 1'b1;
			ST_INIT: begin
				cmd.l_clr     = 1'b1;
				cmd.perm_init = 1'b1;
				cmd.err_clr   = 1'b1;
			end
			ST_K_START:   cmd.best_clr = 1'b1;
			ST_ROW_START: cmd.mx_clr = 1'b1;
			ST_ROW_RD: begin
				cmd.u_re   = 1'b1;
				cmd.u_addr = elem_addr(i, j);
			end
			ST_ROW_CMP: begin
				cmd.mx_upd = 1'b1;
				cmd.cap_a  = (j_q == k_q);
			end
			ST_RATIO: begin
				cmd.div_start = !stat.mx_zero;
				cmd.div_src   = DS_RATIO;
			end
			ST_RATIO_WAIT: cmd.best_upd = stat.div_done;
			ST_SW_RD_K: begin
				cmd.u_re   = 1'b1;
				cmd.l_re   = 1'b1;
				cmd.u_addr = elem_addr(k, j);
				cmd.l_addr = elem_addr(k, j);
			end
			ST_SW_RD_T: begin
				cmd.u_re    = 1'b1;
				cmd.l_re    = 1'b1;
				cmd.u_addr  = elem_addr(t, j);
				cmd.l_addr  = elem_addr(t, j);
				cmd.cap_tmp = 1'b1;
			end
			ST_SW_WR_K: begin
				cmd.u_we   = 1'b1;
				cmd.l_we   = 1'b1;
				cmd.u_addr = elem_addr(k, j);
				cmd.l_addr = elem_addr(k, j);
				cmd.u_wsel = UW_RD;
				cmd.l_wsel = LW_RD;
			end
			ST_SW_WR_T: begin
				cmd.u_we      = 1'b1;
				cmd.l_we      = 1'b1;
				cmd.u_addr    = elem_addr(t, j);
				cmd.l_addr    = elem_addr(t, j);
				cmd.u_wsel    = UW_TMP;
				cmd.l_wsel    = LW_TMP;
				cmd.perm_swap = (j_q == LAST_COL);
			end
			ST_PIV_RD: begin
				cmd.u_re   = 1'b1;
				cmd.u_addr = elem_addr(k, k);
			end
			ST_PIV_CHK: begin
				cmd.cap_piv = 1'b1;
				cmd.err_set = stat.piv_zero;
			end
			ST_EL_RD: begin
				cmd.u_re   = 1'b1;
				cmd.u_addr = elem_addr(i, k);
			end
			ST_EL_DIV: begin
				cmd.div_start = 1'b1;
				cmd.div_src   = DS_ELIM;
			end
			ST_EL_WAIT: cmd.cap_m = stat.div_done;
			ST_EL_WR: begin
				cmd.u_we   = 1'b1;
				cmd.l_we   = 1'b1;
				cmd.u_addr = elem_addr(i, k);
				cmd.l_addr = elem_addr(i, k);
				cmd.u_wsel = UW_ZERO;
				cmd.l_wsel = LW_M;
			end
			ST_MS_RD_K: begin
				cmd.u_re   = 1'b1;
				cmd.u_addr = elem_addr(k, j);
			end
			ST_MS_RD_I: begin
				cmd.u_re     = 1'b1;
				cmd.u_addr   = elem_addr(i, j);
				cmd.cap_prod = 1'b1;
			end
			ST_MS_WR: begin
				cmd.u_we   = 1'b1;
				cmd.u_addr = elem_addr(i, j);
				cmd.u_wsel = UW_MSUB;
			end
			ST_DIAG: begin
				cmd.l_we   = 1'b1;
				cmd.l_addr = elem_addr(i, i);
				cmd.l_wsel = LW_ONE;
			end
			ST_DONE: cmd.out_stat = 1'b1;
			default: ;
		endcase
	end

endmodule

`default_nettype wire

// ===== src/lu_decomposition_scaled_pivot.sv =====
// LU decomposition with scaled partial pivoting, signed Q16.16, n up to 8.
// A write goes straight into the U store; a read result passes the store's read register and
// then the result register. A decompose is paced by the bit-serial divider, used once per
// scale ratio and once per multiplier, and by the single port of the U store.
// One item is in work at a time; a new transfer waits while a result stalls on the output.
// Asynchronous active-low reset: idle, size 8, L reads zero, identity permutation.
`default_nettype none

module lu_decomposition_scaled_pivot (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	// row_index, col_index, element_value, zero fill
	input  wire logic [lusp_pkg::S_TDATA_W-1:0] s_tdata,
	// opcode, matrix_select
	input  wire logic [lusp_pkg::S_TUSER_W-1:0] s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// read_value, status, zero fill
	output logic [lusp_pkg::M_TDATA_W-1:0]      m_tdata,
	// response_kind
	output logic [lusp_pkg::M_TUSER_W-1:0]      m_tuser,
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [lusp_pkg::SIZE_W-1:0]    cfg_data
);
	import lusp_pkg::*;

	lusp_cmd_t         cmd;
	lusp_stat_t        stat;
	logic [IDX_W-1:0]  in_row, in_col;
	logic [DATA_W-1:0] in_value, out_value;
	logic              out_kind, out_status;

	// Unpack the input transfer
	assign in_row   = s_tdata[IDX_W-1:0];
	assign in_col   = s_tdata[2*IDX_W-1:IDX_W];
	assign in_value = s_tdata[2*IDX_W+DATA_W-1:2*IDX_W];

	lusp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_opcode (s_tuser[1:0]),
		.in_row    (in_row),
		.in_col    (in_col),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

	lusp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_value   (in_value),
		.in_row     (in_row),
		.in_col     (in_col),
		.in_sel     (s_tuser[3:2]),
		.out_ready  (m_tready),
		.out_valid  (m_tvalid),
		.out_kind   (out_kind),
		.out_value  (out_value),
		.out_status (out_status)
	);

	// Pack the result transfer
	assign m_tdata = {{(M_TDATA_W-DATA_W-1){1'b0}}, out_status, out_value};
	assign m_tuser = out_kind;

endmodule

`default_nettype wire

// ===== src/lusp_chk.sv =====
// Port-level checker for the LU block, bound to the top level.
// Depends on lusp_pkg and lu_decomposition_scaled_pivot.
`default_nettype none

module lusp_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_tvalid,
	input wire logic                           s_tready,
	input wire logic [lusp_pkg::S_TDATA_W-1:0] s_tdata,
	input wire logic [lusp_pkg::S_TUSER_W-1:0] s_tuser,
	input wire logic                           m_tvalid,
	input wire logic                           m_tready,
	input wire logic [lusp_pkg::M_TDATA_W-1:0] m_tdata,
	input wire logic [lusp_pkg::M_TUSER_W-1:0] m_tuser,
	input wire logic                           cfg_valid,
	input wire logic                           cfg_ready,
	input wire logic [lusp_pkg::SIZE_W-1:0]    cfg_data
);
	import lusp_pkg::*;

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// Status results carry a zero value
	a_stat_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == KIND_STATUS) |-> (m_tdata[DATA_W-1:0] == '0))
		else $error("status result with nonzero value");

	// Read results carry a clear status bit
	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser[0] == KIND_READ) |-> !m_tdata[DATA_W])
		else $error("read result with status set");

	// A write produces no result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser[1:0] == OP_WRITE) && !m_tvalid |=> !m_tvalid)
		else $error("write produced a result");

endmodule

bind lu_decomposition_scaled_pivot lusp_chk u_chk (.*);

`default_nettype wire
